// ===== design/rvh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Raster unique value histogram: shared package
// Field widths, register indexes, word types, the cell control structs, the
// sequencer states and the numeric sort key used by the cells.
// ----------------------------------------------------------------------------
package rvh_pkg;

  // Table and field sizes.
  localparam int TABLE_DEPTH    = 32;
  localparam int COUNT_BITS     = 40;
  localparam int VALUE_BITS     = 64;
  localparam int KEY_BITS       = VALUE_BITS + 1;
  localparam int AREA_BITS      = 48;
  localparam int AREA_OUT_BITS  = 64;
  localparam int PROD_BITS      = COUNT_BITS + AREA_BITS;
  localparam int CFG_INDEX_BITS = 1;

  // IEEE double layout.
  localparam int EXP_MSB  = 62;
  localparam int EXP_LSB  = 52;
  localparam int MANT_MSB = 51;

  localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_BITS-1:0] REG_HONOR_NODATA = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_AREA   = CFG_INDEX_BITS'(1);
  localparam logic [AREA_BITS-1:0]      PIXEL_AREA_RESET = AREA_BITS'(65536);

  // Request and result codes.
  localparam logic REQ_PIXEL    = 1'b0;
  localparam logic REQ_REPORT   = 1'b1;
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Input word.
  typedef struct packed {
    logic                  req_type;
    logic [VALUE_BITS-1:0] pixel_value;
    logic                  is_nodata;
  } rvh_in_t;

  // Result word.
  typedef struct packed {
    logic                     result_kind;
    logic [VALUE_BITS-1:0]    entry_value;
    logic [COUNT_BITS-1:0]    entry_count;
    logic [AREA_OUT_BITS-1:0] entry_area;
    logic [COUNT_BITS-1:0]    nodata_total;
    logic [COUNT_BITS-1:0]    pixel_total;
    logic                     table_overflow;
    logic                     last;
  } rvh_out_t;

  // Contents of one table cell, as handed to a neighbor.
  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
  } rvh_slot_t;

  // Value under test, broadcast to every cell.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [KEY_BITS-1:0]   key;
  } rvh_probe_t;

  // Per-cycle command to the whole chain.
  typedef struct packed {
    logic pixel;   // a value is counted this cycle
    logic insert;  // the value is new and goes into the chain
    logic pop;     // the chain shifts toward the head
  } rvh_cell_ctl_t;

  // Readout sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MULT,
    ST_EMIT,
    ST_SUMMARY
  } rvh_state_t;

  // Unsigned key whose order is the numeric order of doubles, with all NaNs
  // after every number and ordered among themselves by raw bits.
  function automatic logic [KEY_BITS-1:0] sort_key(input logic [VALUE_BITS-1:0] bits);
    logic is_nan;
    logic [KEY_BITS-1:0] key;
    is_nan = (&bits[EXP_MSB:EXP_LSB]) && (|bits[MANT_MSB:0]);
    if (is_nan) begin
      key = {1'b1, bits};
    end else if (bits[VALUE_BITS-1]) begin
      key = {1'b0, ~bits};
    end else begin
      key = {1'b0, bits | SIGN_BIT};
    end
    return key;
  endfunction

endpackage
`default_nettype wire

// ===== design/rvh_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Raster unique value histogram: table cell
// One entry of the sorted chain. It compares the broadcast value with its own,
// counts a match, shifts toward the tail to open a slot for a new value, and
// shifts toward the head during readout.
// ----------------------------------------------------------------------------
module rvh_cell
  import rvh_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rvh_cell_ctl_t ctl,
  input  wire rvh_probe_t    probe,
  input  wire rvh_slot_t     left_slot,
  input  wire logic          left_before,
  input  wire rvh_slot_t     right_slot,
  output      rvh_slot_t     slot,
  output      logic          ahead,
  output      logic          hit
);

  logic                  valid;
  logic [VALUE_BITS-1:0] value;
  logic [COUNT_BITS-1:0] count;
  logic [KEY_BITS-1:0]   key;

  // The new value sorts ahead of this entry, or the entry is empty.
  assign key    = sort_key(value);
  assign ahead  = !valid || (probe.key < key);
  assign hit    = valid && (value == probe.value);
  assign slot   = '{valid: valid, value: value, count: count};

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= right_slot.valid;
    end else if (ctl.insert) begin
      if (left_before) begin
        valid <= left_slot.valid;
      end else if (ahead) begin
        valid <= 1'b1;
      end
    end
  end

  // Value and count. Counts saturate at all ones.
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      value <= right_slot.value;
      count <= right_slot.count;
    end else if (ctl.pixel && hit) begin
      if (!(&count)) begin
        count <= count + COUNT_BITS'(1);
      end
    end else if (ctl.insert) begin
      if (left_before) begin
        value <= left_slot.value;
        count <= left_slot.count;
      end else if (ahead) begin
        value <= probe.value;
        count <= COUNT_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/rvh_area_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Raster unique value histogram: area multiplier
// Multiplies an entry count by the pixel area with one 32 by 32 multiplier,
// one partial product per cycle, and saturates the result to 64 bits.
// ----------------------------------------------------------------------------
module rvh_area_mul
  import rvh_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [COUNT_BITS-1:0]    count_in,
  input  wire logic [AREA_BITS-1:0]     area_in,
  output      logic                     done,
  output      logic [AREA_OUT_BITS-1:0] product
);

  localparam int HALF      = 32;
  localparam int OP_BITS   = 2 * HALF;
  localparam int MUL_STEPS = 4;
  localparam int WIDE_BITS = 2 * OP_BITS;

  logic                 busy;
  logic [2:0]           step;
  logic [OP_BITS-1:0]   cnt_op;
  logic [OP_BITS-1:0]   area_op;
  logic [OP_BITS-1:0]   pp;
  logic [1:0]           pp_shift;
  logic                 pp_ok;
  logic [PROD_BITS-1:0] acc;

  logic [HALF-1:0]      a_sel;
  logic [HALF-1:0]      b_sel;
  logic [OP_BITS-1:0]   mul_res;
  logic [WIDE_BITS-1:0] pp_wide;

  // Step bit 1 picks the count half, step bit 0 the area half.
  assign a_sel   = step[1] ? cnt_op[OP_BITS-1:HALF] : cnt_op[HALF-1:0];
  assign b_sel   = step[0] ? area_op[OP_BITS-1:HALF] : area_op[HALF-1:0];
  assign mul_res = a_sel * b_sel;
  assign pp_wide = {{(WIDE_BITS-OP_BITS){1'b0}}, pp} << {pp_shift, 5'b0};

  // Control: step through the partial products, then add the last one into the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      pp_ok <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        pp_ok <= 1'b0;
      end else if (busy) begin
        pp_ok <= (step < 3'(MUL_STEPS));
        if (step == 3'(MUL_STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands, registered partial product, accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_op  <= OP_BITS'(count_in);
      area_op <= OP_BITS'(area_in);
      step    <= 3'd0;
      acc     <= '0;
    end else if (busy) begin
      step     <= step + 3'd1;
      pp       <= mul_res;
      pp_shift <= {1'b0, step[1]} + {1'b0, step[0]};
      if (pp_ok) begin
        acc <= acc + pp_wide[PROD_BITS-1:0];
      end
    end
  end

  // Saturate to the output width.
  assign product = (|acc[PROD_BITS-1:AREA_OUT_BITS]) ? '1 : acc[AREA_OUT_BITS-1:0];

endmodule
`default_nettype wire

// ===== design/raster_unique_value_histogram_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Raster unique value histogram core
// Counts pixels per distinct double value in a sorted chain of table cells
// and reads the table out in ascending order on a report request.
// ----------------------------------------------------------------------------
// A pixel word is taken in every cycle while the core is idle; all table
// cells compare it in parallel, and a new value is inserted at its sorted
// place in that same cycle, so the table is always kept in ascending order.
// A report word starts the readout, during which input is stalled: each
// entry is popped from the head of the chain, multiplied in the shared 32
// by 32 area multiplier and loaded into the result register once it is
// free, and the summary word follows the last entry. Popping the
// entries empties the table; the counters and the overflow flag clear when
// the summary word is loaded. Result words wait in an output register.
// ----------------------------------------------------------------------------
module raster_unique_value_histogram_core
  import rvh_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire rvh_in_t                   in_data,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      rvh_out_t                  out_data,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [AREA_BITS-1:0]      cfg_data
);

  // Configuration registers.
  logic                 honor_nodata;
  logic [AREA_BITS-1:0] pixel_area;

  // Counters and flags.
  logic [COUNT_BITS-1:0] pixel_counter;
  logic [COUNT_BITS-1:0] nodata_counter;
  logic                  overflow_flag;

  // Sequencer.
  rvh_state_t state;
  rvh_state_t state_next;
  logic       pop;
  logic       mul_start;
  logic       load_entry;
  logic       load_summary;
  logic       out_free;

  // Entry being read out.
  logic [VALUE_BITS-1:0]    cur_value;
  logic [COUNT_BITS-1:0]    cur_count;
  logic                     mul_done;
  logic [AREA_OUT_BITS-1:0] mul_product;

  // Cell chain.
  rvh_slot_t            cell_slot [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_before;
  logic [TABLE_DEPTH-1:0] cell_hit;
  rvh_cell_ctl_t        ctl;
  rvh_probe_t           probe;

  logic                  in_accept;
  logic                  px_accept;
  logic                  to_table;
  logic                  any_hit;
  logic                  full;
  logic [VALUE_BITS-1:0] norm_value;

  // Configuration write port; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      honor_nodata <= 1'b1;
      pixel_area   <= PIXEL_AREA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HONOR_NODATA: honor_nodata <= cfg_data[0];
        REG_PIXEL_AREA:   pixel_area   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Input decode. Minus zero is folded into plus zero.
  assign in_accept  = in_valid && !in_stall;
  assign px_accept  = in_accept && (in_data.req_type == REQ_PIXEL);
  assign to_table   = px_accept && !(honor_nodata && in_data.is_nodata);
  assign norm_value = (in_data.pixel_value == SIGN_BIT) ? '0 : in_data.pixel_value;

  assign any_hit = |cell_hit;
  assign full    = cell_slot[TABLE_DEPTH-1].valid;

  assign probe.value = norm_value;
  assign probe.key   = sort_key(norm_value);
  assign ctl.pixel   = to_table;
  assign ctl.insert  = to_table && !any_hit && !full;
  assign ctl.pop     = pop;

  // The chain: cell zero holds the smallest value.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rvh_slot_t left_slot;
    rvh_slot_t right_slot;
    logic      left_before;

    if (i == 0) begin : g_head
      assign left_slot   = '0;
      assign left_before = 1'b0;
    end else begin : g_body
      assign left_slot   = cell_slot[i-1];
      assign left_before = cell_before[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_next
      assign right_slot = cell_slot[i+1];
    end

    rvh_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .probe       (probe),
      .left_slot   (left_slot),
      .left_before (left_before),
      .right_slot  (right_slot),
      .slot        (cell_slot[i]),
      .ahead       (cell_before[i]),
      .hit         (cell_hit[i])
    );
  end

  // Pixel, nodata and overflow bookkeeping; cleared with the summary.
  always_ff @(posedge clk) begin
    if (rst || load_summary) begin
      pixel_counter  <= '0;
      nodata_counter <= '0;
      overflow_flag  <= 1'b0;
    end else if (px_accept) begin
      if (!(&pixel_counter)) begin
        pixel_counter <= pixel_counter + COUNT_BITS'(1);
      end
      if (!to_table && !(&nodata_counter)) begin
        nodata_counter <= nodata_counter + COUNT_BITS'(1);
      end
      if (to_table && !any_hit && full) begin
        overflow_flag <= 1'b1;
      end
    end
  end

  // Area multiplier for the entry being read out.
  rvh_area_mul u_area_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .count_in (cell_slot[0].count),
    .area_in  (pixel_area),
    .done     (mul_done),
    .product  (mul_product)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_value <= cell_slot[0].value;
      cur_count <= cell_slot[0].count;
    end
  end

  // Readout sequencer: state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !out_valid || !out_stall;

  // Readout sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (in_data.req_type == REQ_REPORT)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = cell_slot[0].valid ? ST_MULT : ST_SUMMARY;
      end
      ST_MULT: begin
        if (mul_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_FETCH;
        end
      end
      ST_SUMMARY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Readout sequencer: outputs.
  always_comb begin
    in_stall     = 1'b1;
    pop          = 1'b0;
    mul_start    = 1'b0;
    load_entry   = 1'b0;
    load_summary = 1'b0;
    unique case (state)
      ST_IDLE:    in_stall = 1'b0;
      ST_FETCH: begin
        pop       = cell_slot[0].valid;
        mul_start = cell_slot[0].valid;
      end
      ST_MULT:    ;
      ST_EMIT:    load_entry = out_free;
      ST_SUMMARY: load_summary = out_free;
      default:    ;
    endcase
  end

  // Output register: control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_entry || load_summary) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: word.
  always_ff @(posedge clk) begin
    if (load_entry) begin
      out_data <= '{
        result_kind:    KIND_ENTRY,
        entry_value:    cur_value,
        entry_count:    cur_count,
        entry_area:     mul_product,
        nodata_total:   '0,
        pixel_total:    '0,
        table_overflow: 1'b0,
        last:           1'b0
      };
    end else if (load_summary) begin
      out_data <= '{
        result_kind:    KIND_SUMMARY,
        entry_value:    '0,
        entry_count:    '0,
        entry_area:     '0,
        nodata_total:   nodata_counter,
        pixel_total:    pixel_counter,
        table_overflow: overflow_flag,
        last:           1'b1
      };
    end
  end

endmodule
`default_nettype wire

// ===== dv/raster_unique_value_histogram_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Raster unique value histogram core testbench
// Streams pixel and report words into the core through a bursty sender while
// the result side stalls on its own pattern. A behavioral histogram kept in
// the bench predicts every sorted readout, and each result word is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module raster_unique_value_histogram_core_tb;
  import rvh_pkg::*;

  localparam int LIMIT_CYCLES   = 1_500_000;
  localparam int IDLE_SETTLE    = 16;
  localparam int END_SETTLE     = 40;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 50;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int AREA_REPEATS   = 8;

  // Clock, reset and the ports of the core.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  rvh_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rvh_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [AREA_BITS-1:0] cfg_data = '0;

  // Behavioral histogram and its register copies.
  logic [VALUE_BITS-1:0] tab_value [TABLE_DEPTH];
  logic                  tab_used  [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] tab_count [TABLE_DEPTH];
  logic [COUNT_BITS-1:0] nodata_seen;
  logic [COUNT_BITS-1:0] pixels_seen;
  logic                  dropped_value;
  logic                  honor_nodata_cfg = 1'b1;
  logic [AREA_BITS-1:0]  pixel_area_cfg = PIXEL_AREA_RESET;
  rvh_out_t              readout_words [$];

  // Run bookkeeping.
  int mismatches = 0;
  int words_accepted = 0;
  int reports_seen = 0;
  int results_checked = 0;
  int settings_applied = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_request = 0;
  int hold_left = 0;
  int pattern_left = 0;
  int stall_pct = 0;

  raster_unique_value_histogram_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Saturating counter step.
  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // True when value a is listed ahead of value b: numbers in numeric order,
  // then every NaN, the NaNs ordered by raw bits.
  function automatic logic value_precedes(input logic [VALUE_BITS-1:0] a,
                                          input logic [VALUE_BITS-1:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (&a[EXP_MSB:EXP_LSB]) && (|a[MANT_MSB:0]);
    b_nan = (&b[EXP_MSB:EXP_LSB]) && (|b[MANT_MSB:0]);
    if (a_nan || b_nan) begin
      return b_nan && (!a_nan || a < b);
    end
    if (a[VALUE_BITS-1] != b[VALUE_BITS-1]) begin
      return a[VALUE_BITS-1];
    end
    return a[VALUE_BITS-1] ? (a > b) : (a < b);
  endfunction

  // Count times pixel area, clamped to the output width.
  function automatic logic [AREA_OUT_BITS-1:0] area_for(input logic [COUNT_BITS-1:0] c);
    logic [PROD_BITS-1:0] prod;
    prod = c * pixel_area_cfg;
    return (|prod[PROD_BITS-1:AREA_OUT_BITS]) ? '1 : prod[AREA_OUT_BITS-1:0];
  endfunction

  // Draws a double bit pattern, favoring the special encodings.
  function automatic logic [VALUE_BITS-1:0] fresh_value();
    logic [MANT_MSB:0] mant;
    logic sign;
    mant = {20'($urandom()), 32'($urandom())};
    sign = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: begin
        return {sign, 11'h7FF, 52'h0};
      end
      1: begin
        return {sign, 11'h7FF, (mant == '0) ? 52'h1 : mant};
      end
      2: begin
        return {sign, 63'h0};
      end
      3: begin
        return {sign, 11'h000, mant};
      end
      default: begin
        return {$urandom(), $urandom()};
      end
    endcase
  endfunction

  task automatic clear_histogram();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tab_used[i] = 1'b0;
      tab_count[i] = '0;
    end
    nodata_seen = '0;
    pixels_seen = '0;
    dropped_value = 1'b0;
  endtask

  // Counts one pixel word into the behavioral histogram.
  task automatic count_pixel(input rvh_in_t w);
    logic [VALUE_BITS-1:0] v;
    int free_slot;
    free_slot = -1;
    pixels_seen = bump(pixels_seen);
    if (honor_nodata_cfg && w.is_nodata) begin
      nodata_seen = bump(nodata_seen);
      return;
    end
    // Minus zero is kept as plus zero.
    v = (w.pixel_value == SIGN_BIT) ? '0 : w.pixel_value;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tab_used[i] && tab_value[i] == v) begin
        tab_count[i] = bump(tab_count[i]);
        return;
      end
      if (!tab_used[i] && free_slot < 0) begin
        free_slot = i;
      end
    end
    if (free_slot < 0) begin
      dropped_value = 1'b1;
    end else begin
      tab_value[free_slot] = v;
      tab_used[free_slot] = 1'b1;
      tab_count[free_slot] = 1;
    end
  endtask

  // Queues the sorted entry words and the summary word, then clears.
  task automatic queue_readout();
    int order [$];
    int pos;
    rvh_out_t word;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tab_used[i]) begin
        pos = 0;
        while (pos < order.size() && !value_precedes(tab_value[i], tab_value[order[pos]])) begin
          pos++;
        end
        order.insert(pos, i);
      end
    end
    foreach (order[k]) begin
      word = '0;
      word.result_kind = KIND_ENTRY;
      word.entry_value = tab_value[order[k]];
      word.entry_count = tab_count[order[k]];
      word.entry_area = area_for(tab_count[order[k]]);
      readout_words.push_back(word);
    end
    word = '0;
    word.result_kind = KIND_SUMMARY;
    word.nodata_total = nodata_seen;
    word.pixel_total = pixels_seen;
    word.table_overflow = dropped_value;
    word.last = 1'b1;
    readout_words.push_back(word);
    clear_histogram();
  endtask

  // Predicts the effect of every accepted input word.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      words_accepted++;
      if (in_data.req_type == REQ_REPORT) begin
        reports_seen++;
        queue_readout();
      end else begin
        count_pixel(in_data);
      end
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Checks each accepted result word against the oldest prediction.
  always @(posedge clk) begin : result_checker
    rvh_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (readout_words.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = readout_words.pop_front();
        results_checked++;
        compare_field("result_kind", want.result_kind, out_data.result_kind);
        compare_field("entry_value", want.entry_value, out_data.entry_value);
        compare_field("entry_count", want.entry_count, out_data.entry_count);
        compare_field("entry_area", want.entry_area, out_data.entry_area);
        compare_field("nodata_total", want.nodata_total, out_data.nodata_total);
        compare_field("pixel_total", want.pixel_total, out_data.pixel_total);
        compare_field("table_overflow", want.table_overflow, out_data.table_overflow);
        compare_field("last", want.last, out_data.last);
      end
    end
  end

  // Result side: stretches of random stall density, plus a long hold-off
  // when one is requested.
  always @(posedge clk) begin
    logic stall_now;
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(8, 60);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      pattern_left--;
      stall_now = ($urandom_range(0, 99) < stall_pct);
    end
    out_stall <= stall_now;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Run limit of %0d cycles reached with %0d result words outstanding.",
               LIMIT_CYCLES, readout_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one word and waits until the core takes it; the sender runs in
  // bursts, most of them separated by idle gaps.
  task automatic send_word(input rvh_in_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_pixel(input logic [VALUE_BITS-1:0] v, input logic nodata);
    rvh_in_t w;
    w.req_type = REQ_PIXEL;
    w.pixel_value = v;
    w.is_nodata = nodata;
    send_word(w);
  endtask

  // The payload of a report word carries random bits that must be ignored.
  task automatic send_report();
    rvh_in_t w;
    w.req_type = REQ_REPORT;
    w.pixel_value = {$urandom(), $urandom()};
    w.is_nodata = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  // Stops sending and waits until every predicted word has arrived and the
  // core has had time to settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (readout_words.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Writes both registers while the core is idle. Spare bits of the nodata
  // word are random and must be ignored.
  task automatic configure(input logic honor, input logic [AREA_BITS-1:0] area);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_HONOR_NODATA;
    cfg_data <= {(AREA_BITS-1)'($urandom()), honor};
    do @(posedge clk); while (!cfg_ready);
    honor_nodata_cfg = honor;
    cfg_index <= REG_PIXEL_AREA;
    cfg_data <= area;
    do @(posedge clk); while (!cfg_ready);
    pixel_area_cfg = area;
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // Reset settings: an empty report, then the special encodings and a
  // nodata pixel.
  task automatic test_special_values();
    logic [VALUE_BITS-1:0] specials [$] = '{
      64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000,
      64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
      64'hFFEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001,
      64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000};
    send_report();
    foreach (specials[i]) begin
      send_pixel(specials[i], 1'b0);
    end
    send_pixel(64'h3FF0_0000_0000_0000, 1'b1);
    send_report();
  endtask

  // Nodata handling off: flagged pixels count as values; zero pixel area.
  task automatic test_nodata_as_value();
    configure(1'b0, '0);
    send_pixel(64'h4000_0000_0000_0000, 1'b1);
    send_pixel(64'h4000_0000_0000_0000, 1'b0);
    send_pixel(64'h8000_0000_0000_0000, 1'b1);
    send_pixel(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_report();
  endtask

  // Fills every table entry, then offers new values that must be dropped.
  task automatic test_table_full();
    configure(1'b1, AREA_BITS'({$urandom(), $urandom()}));
    for (int i = 0; i < TABLE_DEPTH + 4; i++) begin
      send_pixel({32'($urandom()) | 32'h1, 32'(i)}, 1'b0);
    end
    send_pixel(tab_value[0], 1'b0);
    send_pixel(fresh_value(), 1'b1);
    send_report();
  endtask

  // Largest pixel area: entry areas use every bit of the area register.
  task automatic test_largest_area();
    configure(1'b1, '1);
    for (int i = 0; i < AREA_REPEATS; i++) begin
      send_pixel(64'h3FF0_0000_0000_0000, 1'b0);
      if (i % 3 == 0) begin
        send_pixel(64'hC000_0000_0000_0000, 1'b0);
      end
    end
    send_report();
  endtask

  // The result side holds off during a readout while pixels keep coming, so
  // the core backs up and stalls its input.
  task automatic test_output_hold_off();
    configure(1'b1, PIXEL_AREA_RESET);
    repeat (20) send_pixel(fresh_value(), 1'b0);
    hold_request = HOLD_OFF_LEN;
    send_report();
    repeat (30) send_pixel(fresh_value(), 1'($urandom_range(0, 1)));
    send_report();
  endtask

  // Phases of random pixels drawn mostly from a small pool of values, each
  // phase under its own register setting.
  task automatic test_random_phases();
    logic [VALUE_BITS-1:0] pool [$];
    logic [AREA_BITS-1:0] area;
    int roll;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0: area = '0;
        1: area = '1;
        2: area = PIXEL_AREA_RESET;
        default: area = AREA_BITS'({$urandom(), $urandom()});
      endcase
      configure(1'($urandom_range(0, 1)), area);
      pool.delete();
      repeat ($urandom_range(2, 44)) pool.push_back(fresh_value());
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          send_report();
        end else if (roll < 16) begin
          send_pixel(pool[$urandom_range(0, pool.size() - 1)], 1'b1);
        end else if (roll < 90) begin
          send_pixel(pool[$urandom_range(0, pool.size() - 1)], 1'b0);
        end else begin
          send_pixel(fresh_value(), 1'($urandom_range(0, 1)));
        end
      end
      send_report();
    end
  endtask

  initial begin
    clear_histogram();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_values();
    test_nodata_as_value();
    test_table_full();
    test_largest_area();
    test_output_hold_off();
    test_random_phases();
    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    $display("Sent %0d input words including %0d reports; checked %0d result words.",
             words_accepted, reports_seen, results_checked);
    $display("Ran under %0d register settings, with a full table and the largest pixel area.",
             settings_applied);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rvh_pkg.sv
design/rvh_cell.sv
design/rvh_area_mul.sv
design/raster_unique_value_histogram_core.sv
dv/raster_unique_value_histogram_core_tb.sv
